[hdl/kct_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kct_pkg
// Shared types and constants of the keyed counter table.
// ----------------------------------------------------------------------------
package kct_pkg;

   localparam int REQ_TYPE_W = 2;
   localparam int KEY_W      = 32;
   localparam int COUNT_W    = 31;
   localparam int STATUS_W   = 3;
   localparam int ENTRY_W    = 2 * COUNT_W;   // stored key (31) + count (31)

   // request codes; code three is unnamed and behaves as a get
   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_ADD = 2'd0,
      REQ_GET = 2'd1,
      REQ_SET = 2'd2
   } req_code_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_NEG_KEY   = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_FULL      = 3'd3,
      ST_NEG_COUNT = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      RES_ZERO = 2'd0,
      RES_ONE  = 2'd1,
      RES_UPD  = 2'd2
   } res_src_type;

   // controller -> datapath
   typedef struct packed {
      logic        load;
      logic        rd_en;
      logic        addr_inc;
      logic        wr_hit;
      logic        wr_new;
      logic        res_load;
      res_src_type res_src;
      status_type  res_status;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic neg_key;
      logic neg_count;
      logic is_add;
      logic is_set;
      logic empty;
      logic full;
      logic last;
      logic match;
   } dp_status_type;

endpackage

[hdl/kct_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kct_req_if / kct_rsp_if
// Valid/ready channels carrying requests into and results out of the table.
// ----------------------------------------------------------------------------
interface kct_req_if;
   logic                                   valid;
   logic                                   ready;
   logic        [kct_pkg::REQ_TYPE_W-1:0] req_type;
   logic signed [kct_pkg::KEY_W-1:0]      key;
   logic signed [kct_pkg::KEY_W-1:0]      new_count;

   modport source (output valid, req_type, key, new_count, input ready);
   modport sink   (input valid, req_type, key, new_count, output ready);
endinterface

interface kct_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [kct_pkg::COUNT_W-1:0]      count_out;
   logic [kct_pkg::STATUS_W-1:0]     status;

   modport source (output valid, count_out, status, input ready);
   modport sink   (input valid, count_out, status, output ready);
endinterface

[hdl/kct_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kct_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module kct_ram #(
   parameter int WIDTH = 62,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/kct_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kct_dp
// Datapath: request registers, slot memory, scan pointer, fill count, result.
// ----------------------------------------------------------------------------
module kct_dp #(
   parameter int ENTRIES = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  kct_pkg::cmd_type                  cmd,
   output kct_pkg::dp_status_type            sts,
   input  logic [kct_pkg::REQ_TYPE_W-1:0]    req_type,
   input  logic signed [kct_pkg::KEY_W-1:0]  key,
   input  logic signed [kct_pkg::KEY_W-1:0]  new_count,
   output logic [kct_pkg::COUNT_W-1:0]       count_out,
   output logic [kct_pkg::STATUS_W-1:0]      status
);

   localparam int AW = $clog2(ENTRIES);
   localparam int FW = $clog2(ENTRIES + 1);
   localparam int CW = kct_pkg::COUNT_W;

   logic [kct_pkg::REQ_TYPE_W-1:0] req_type_ff;
   logic [kct_pkg::KEY_W-1:0]      key_ff;
   logic [kct_pkg::KEY_W-1:0]      new_count_ff;
   logic [AW-1:0]                  addr_ff, addr_in;
   logic [FW-1:0]                  fill_ff, fill_in;
   logic [CW-1:0]                  count_ff, count_in;
   kct_pkg::status_type            status_ff, status_in;

   logic                           wr_en;
   logic [AW-1:0]                  wr_addr;
   logic [kct_pkg::ENTRY_W-1:0]    wr_data;
   logic [kct_pkg::ENTRY_W-1:0]    rd_data;
   logic [CW-1:0]                  rd_key;
   logic [CW-1:0]                  rd_count;
   logic [CW-1:0]                  upd_count;

   assign rd_key   = rd_data[kct_pkg::ENTRY_W-1:CW];
   assign rd_count = rd_data[CW-1:0];

   // read address follows the pointer's next value: one slot per cycle
   always_comb begin
      addr_in = addr_ff;
      if (cmd.load) begin
         addr_in = '0;
      end else if (cmd.addr_inc) begin
         addr_in = addr_ff + AW'(1);
      end
   end

   always_comb begin
      fill_in = fill_ff;
      if (cmd.wr_new) begin
         fill_in = fill_ff + FW'(1);
      end
   end

   // updated count on a hit: saturating increment, set value, or unchanged
   always_comb begin
      if (req_type_ff == kct_pkg::REQ_ADD) begin
         upd_count = (rd_count == {CW{1'b1}}) ? rd_count : rd_count + CW'(1);
      end else if (req_type_ff == kct_pkg::REQ_SET) begin
         upd_count = new_count_ff[CW-1:0];
      end else begin
         upd_count = rd_count;
      end
   end

   always_comb begin
      wr_en   = cmd.wr_hit | cmd.wr_new;
      wr_addr = cmd.wr_new ? fill_ff[AW-1:0] : addr_ff;
      wr_data = cmd.wr_new ? {key_ff[CW-1:0], CW'(1)} : {key_ff[CW-1:0], upd_count};
   end

   always_comb begin
      count_in  = count_ff;
      status_in = status_ff;
      if (cmd.res_load) begin
         status_in = cmd.res_status;
         case (cmd.res_src)
            kct_pkg::RES_ONE: count_in = CW'(1);
            kct_pkg::RES_UPD: count_in = upd_count;
            default:          count_in = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
      if (cmd.load) begin
         req_type_ff  <= req_type;
         key_ff       <= key;
         new_count_ff <= new_count;
      end
      addr_ff   <= addr_in;
      count_ff  <= count_in;
      status_ff <= status_in;
   end

   kct_ram #(
      .WIDTH (kct_pkg::ENTRY_W),
      .DEPTH (ENTRIES)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (addr_in),
      .rd_data (rd_data)
   );

   always_comb begin
      sts.neg_key   = key_ff[kct_pkg::KEY_W-1];
      sts.neg_count = new_count_ff[kct_pkg::KEY_W-1];
      sts.is_add    = (req_type_ff == kct_pkg::REQ_ADD);
      sts.is_set    = (req_type_ff == kct_pkg::REQ_SET);
      sts.empty     = (fill_ff == '0);
      sts.full      = (fill_ff == FW'(ENTRIES));
      sts.last      = ((FW'(addr_ff) + FW'(1)) == fill_ff);
      sts.match     = (rd_key == key_ff[CW-1:0]);
   end

   assign count_out = count_ff;
   assign status    = status_ff;

endmodule

[hdl/kct_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kct_ctrl
// Sequencer: takes a request, steps the slot scan, loads and hands out result.
// ----------------------------------------------------------------------------
module kct_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  kct_pkg::dp_status_type sts,
   output kct_pkg::cmd_type       cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_CHECK,
      S_SCAN,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      miss;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      miss     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (sts.neg_key) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = kct_pkg::ST_NEG_KEY;
               state_in       = S_DONE;
            end else if (sts.is_set && sts.neg_count) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = kct_pkg::ST_NEG_COUNT;
               state_in       = S_DONE;
            end else if (sts.empty) begin
               miss     = 1'b1;
               state_in = S_DONE;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = S_SCAN;
            end
         end
         S_SCAN: begin
            if (sts.match) begin
               cmd.wr_hit     = sts.is_add | sts.is_set;
               cmd.res_load   = 1'b1;
               cmd.res_src    = kct_pkg::RES_UPD;
               cmd.res_status = kct_pkg::ST_OK;
               state_in       = S_DONE;
            end else if (sts.last) begin
               miss     = 1'b1;
               state_in = S_DONE;
            end else begin
               cmd.rd_en    = 1'b1;
               cmd.addr_inc = 1'b1;
            end
         end
         S_DONE: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // key not in the table: insert on add if room, else report
      if (miss) begin
         cmd.res_load = 1'b1;
         if (sts.is_add && !sts.full) begin
            cmd.wr_new     = 1'b1;
            cmd.res_src    = kct_pkg::RES_ONE;
            cmd.res_status = kct_pkg::ST_OK;
         end else if (sts.is_add) begin
            cmd.res_status = kct_pkg::ST_FULL;
         end else begin
            cmd.res_status = kct_pkg::ST_NOT_FOUND;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_DONE);

endmodule

[hdl/keyed_counter_table.sv]
`timescale 1ns / 1ps
// Keyed counter table: ENTRIES key/count slots, filled from slot 0 upward and
// never freed. Each request is add (increment, or insert with count 1),
// get, or set (overwrite an existing key only). Negative keys and negative
// set counts are rejected; counts saturate at 2^31-1. One request is in
// flight at a time: it is taken, then checked in the next cycle, then the
// slot memory is scanned one slot per cycle through its single registered
// read port, stopping at the first match or after the last filled slot;
// rejected requests and an empty table skip the scan. The result is held
// until rsp_if.ready. Reset empties the table at once: the fill count marks
// which slots are live.
// ----------------------------------------------------------------------------
// keyed_counter_table
// Top level: sequencer plus datapath with the slot memory.
// ----------------------------------------------------------------------------
module keyed_counter_table #(
   parameter int ENTRIES = 64   // 2 .. 1024
) (
   input  logic     clock,
   input  logic     reset,
   kct_req_if.sink  req_if,
   kct_rsp_if.source rsp_if
);

   kct_pkg::cmd_type       cmd;   // sequencer commands
   kct_pkg::dp_status_type sts;   // datapath flags: checks, match, scan end

   kct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // request fields are latched on acceptance; result held until taken
   kct_dp #(
      .ENTRIES (ENTRIES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_type  (req_if.req_type),
      .key       (req_if.key),
      .new_count (req_if.new_count),
      .count_out (rsp_if.count_out),
      .status    (rsp_if.status)
   );

endmodule

[verif/keyed_counter_table_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_counter_table_tb
// Self-checking bench for the keyed counter table. A directed opening covers
// the rejections, saturation, the spare request code and insert/hit paths.
// A long random run then fills the table, overflows it and mixes hits,
// misses and overwrites. Every result is checked against a mirror of the
// table kept in the bench, with random idling on both channels.
// ----------------------------------------------------------------------------
module keyed_counter_table_tb;
   import kct_pkg::*;

   localparam int ENTRIES      = 64;
   localparam int KEY_POOL     = 70;
   localparam int RANDOM_REQS  = 1330;
   localparam int CALM_TAIL    = 120;            // last requests run with no idling
   localparam int DRAIN_CYCLES = ENTRIES + 16;   // one full scan plus margin
   localparam int CYCLE_LIMIT  = 1000000;

   localparam logic [COUNT_W-1:0]    COUNT_MAX     = '1;
   localparam logic [REQ_TYPE_W-1:0] REQ_SPARE_GET = 2'd3;  // unnamed code, reads as a get

   typedef struct {
      logic        [REQ_TYPE_W-1:0] kind;
      logic signed [KEY_W-1:0]      key;
      logic signed [KEY_W-1:0]      new_count;
   } tally_req_type;

   typedef struct {
      logic [COUNT_W-1:0] count;
      status_type         status;
   } tally_rsp_type;

   logic clock;
   logic reset = 1'b1;

   kct_req_if req_if ();
   kct_rsp_if rsp_if ();

   keyed_counter_table #(
      .ENTRIES(ENTRIES)
   ) DUT (
      .clock (clock),
      .reset (reset),
      .req_if(req_if),
      .rsp_if(rsp_if)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Mirror of the table. Slots fill from 0 upward and are never freed, so
   // a slot is live exactly when its index is below the fill level.
   logic [COUNT_W-1:0] mirror_key   [ENTRIES];
   logic [COUNT_W-1:0] mirror_count [ENTRIES];
   int                 mirror_fill;

   tally_req_type pending_reqs [$];   // requests still to be driven
   tally_rsp_type counts_due   [$];   // expected results, oldest first

   int faults;
   int accepted;
   int returned;
   int cycles;
   int status_seen [5];

   // Applies one request to the mirror and returns the result it must give.
   function automatic tally_rsp_type update_mirror(tally_req_type r);
      tally_rsp_type      res;
      logic [COUNT_W-1:0] k;
      int                 hit;
      int                 i;
      res.count  = '0;
      res.status = ST_OK;
      k          = r.key[COUNT_W-1:0];
      hit        = -1;
      if (r.key[KEY_W-1]) begin
         // a negative key is refused before anything else is looked at
         res.status = ST_NEG_KEY;
         return res;
      end
      for (i = 0; i < mirror_fill; i++) begin
         if (hit < 0 && mirror_key[i] == k) begin
            hit = i;
         end
      end
      if (r.kind == REQ_ADD) begin
         if (hit >= 0) begin
            if (mirror_count[hit] != COUNT_MAX) begin
               mirror_count[hit] = mirror_count[hit] + COUNT_W'(1);
            end
            res.count = mirror_count[hit];
         end else if (mirror_fill < ENTRIES) begin
            mirror_key[mirror_fill]   = k;
            mirror_count[mirror_fill] = COUNT_W'(1);
            mirror_fill++;
            res.count = COUNT_W'(1);
         end else begin
            res.status = ST_FULL;
         end
      end else if (r.kind == REQ_SET) begin
         // the count sign is judged before the lookup; set never inserts
         if (r.new_count[KEY_W-1]) begin
            res.status = ST_NEG_COUNT;
         end else if (hit >= 0) begin
            mirror_count[hit] = r.new_count[COUNT_W-1:0];
            res.count         = mirror_count[hit];
         end else begin
            res.status = ST_NOT_FOUND;
         end
      end else begin
         // get, and the spare code which behaves the same
         if (hit >= 0) begin
            res.count = mirror_count[hit];
         end else begin
            res.status = ST_NOT_FOUND;
         end
      end
      return res;
   endfunction

   task automatic queue_req(logic [REQ_TYPE_W-1:0] kind, logic [KEY_W-1:0] key,
                            logic [KEY_W-1:0] new_count);
      tally_req_type r;
      r.kind      = kind;
      r.key       = key;
      r.new_count = new_count;
      pending_reqs.push_back(r);
   endtask

   task automatic flag_fault(string text);
      faults++;
      if (faults <= 10) begin
         $display("[%0t] MISMATCH: %s", $realtime, text);
      end
   endtask

   // ---------------------------------------------------------------------
   // Request driver. The mirror is updated at the edge where a request is
   // taken; the block handles one request at a time, so the order of
   // expectations is the order of acceptance.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : req_driver
      tally_rsp_type due;
      tally_req_type in_flight;
      int            req_gap;
      if (reset) begin
         req_if.valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            due = update_mirror(in_flight);
            counts_due.push_back(due);
            accepted++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_if.valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               in_flight = pending_reqs.pop_front();
               req_if.valid     <= 1'b1;
               req_if.req_type  <= in_flight.kind;
               req_if.key       <= in_flight.key;
               req_if.new_count <= in_flight.new_count;
               // idle burst after this request, none in the closing stretch
               if (pending_reqs.size() >= CALM_TAIL && $urandom_range(0, 3) == 0) begin
                  req_gap = $urandom_range(1, 6);
               end
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result monitor: checks each accepted result against the oldest
   // expectation and stalls ready in random bursts.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : rsp_monitor
      tally_rsp_type due;
      int            rsp_hold;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            returned++;
            if (counts_due.size() == 0) begin
               flag_fault($sformatf("result with nothing pending: count %0h status %0d",
                                    rsp_if.count_out, rsp_if.status));
            end else begin
               due = counts_due.pop_front();
               status_seen[int'(due.status)]++;
               if (rsp_if.count_out !== due.count) begin
                  flag_fault($sformatf("result %0d count_out: expected %0h, got %0h",
                                       returned, due.count, rsp_if.count_out));
               end
               if (rsp_if.status !== due.status) begin
                  flag_fault($sformatf("result %0d status: expected %0d (%s), got %0d",
                                       returned, due.status, due.status.name(),
                                       rsp_if.status));
               end
            end
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_if.ready <= 1'b0;
         end else if (pending_reqs.size() >= CALM_TAIL && $urandom_range(0, 7) == 0) begin
            rsp_hold = $urandom_range(1, 6) - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles: %0d accepted, %0d results, %0d outstanding",
                  cycles, accepted, returned, counts_due.size());
         $display("keyed_counter_table_tb: errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus and end of run
   // ---------------------------------------------------------------------
   initial begin : stimulus
      logic [KEY_W-1:0]      key_pool [KEY_POOL];
      logic [KEY_W-1:0]      k;
      logic [KEY_W-1:0]      c;
      logic [REQ_TYPE_W-1:0] kind;
      int                    pick;
      int                    n;
      int                    total_reqs;

      req_if.valid     = 1'b0;
      req_if.req_type  = REQ_GET;
      req_if.key       = '0;
      req_if.new_count = '0;
      rsp_if.ready     = 1'b0;
      mirror_fill      = 0;
      faults           = 0;
      accepted         = 0;
      returned         = 0;
      cycles           = 0;
      foreach (status_seen[i]) status_seen[i] = 0;

      // --- directed opening ---
      queue_req(REQ_GET, 32'd5, 32'd0);                   // get on an empty table
      queue_req(REQ_SET, 32'd5, 32'd10);                  // set of an absent key, no insert
      queue_req(REQ_ADD, 32'd5, 32'hFFFF_FFFF);           // insert with count 1
      queue_req(REQ_ADD, 32'd5, 32'd0);                   // hit, increment
      queue_req(REQ_GET, 32'd5, 32'h8000_0000);
      queue_req(REQ_SPARE_GET, 32'd5, 32'd0);             // spare code reads like get
      queue_req(REQ_SET, 32'd5, 32'h7FFF_FFFE);
      queue_req(REQ_ADD, 32'd5, 32'd0);                   // reaches the maximum
      queue_req(REQ_ADD, 32'd5, 32'd0);                   // saturates
      queue_req(REQ_SET, 32'd5, 32'hFFFF_FFFF);           // negative count
      queue_req(REQ_SET, 32'd5, 32'h8000_0000);           // most negative count
      queue_req(REQ_GET, 32'd5, 32'd0);                   // still saturated
      queue_req(REQ_ADD, 32'd0, 32'd0);                   // smallest key
      queue_req(REQ_ADD, 32'h7FFF_FFFF, 32'd0);           // largest key
      queue_req(REQ_GET, 32'h7FFF_FFFF, 32'd0);
      queue_req(REQ_ADD, 32'h8000_0000, 32'd0);           // negative key on each request type
      queue_req(REQ_GET, 32'hFFFF_FFFF, 32'd0);
      queue_req(REQ_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);   // key is judged first
      queue_req(REQ_SPARE_GET, 32'h8000_0000, 32'd0);
      queue_req(REQ_SET, 32'd0, 32'h7FFF_FFFF);           // set to the maximum
      queue_req(REQ_SET, 32'd0, 32'd0);                   // set to zero
      queue_req(REQ_ADD, 32'd0, 32'd0);
      queue_req(REQ_SPARE_GET, 32'd12345, 32'd0);         // spare code, absent key
      queue_req(REQ_SET, 32'h7FFF_FFFE, 32'd7);           // absent, next to the largest

      // --- random part: a key pool makes hits likely; fresh keys fill the
      // table early, after which new keys are refused as full ---
      for (n = 0; n < KEY_POOL; n++) begin
         key_pool[n] = (n < 8) ? n : ($urandom & 32'h7FFF_FFFF);
      end
      for (n = 0; n < RANDOM_REQS; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            kind = REQ_ADD;
         end else if (pick < 65) begin
            kind = REQ_GET;
         end else if (pick < 90) begin
            kind = REQ_SET;
         end else begin
            kind = REQ_SPARE_GET;
         end
         pick = $urandom_range(0, 99);
         if (pick < 75) begin
            k = key_pool[$urandom_range(0, KEY_POOL - 1)];
         end else if (pick < 85) begin
            k = $urandom & 32'h7FFF_FFFF;
         end else begin
            k = $urandom | 32'h8000_0000;
         end
         pick = $urandom_range(0, 99);
         if (kind != REQ_SET) begin
            c = $urandom;                        // ignored by the block
         end else if (pick < 10) begin
            c = $urandom | 32'h8000_0000;
         end else if (pick < 25) begin
            c = 32'h7FFF_FFFF - $urandom_range(0, 3);   // near the ceiling
         end else if (pick < 50) begin
            c = $urandom_range(0, 20);
         end else begin
            c = $urandom & 32'h7FFF_FFFF;
         end
         queue_req(kind, k, c);
      end
      total_reqs = pending_reqs.size();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (accepted < total_reqs) @(posedge clock);
      while (counts_due.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d requests with %0d results: ok %0d, negative key %0d, missing %0d,",
               accepted, returned, status_seen[ST_OK], status_seen[ST_NEG_KEY],
               status_seen[ST_NOT_FOUND]);
      $display("  full %0d, negative count %0d; table held %0d of %0d slots; %0d mismatches",
               status_seen[ST_FULL], status_seen[ST_NEG_COUNT], mirror_fill, ENTRIES, faults);
      if (faults == 0 && counts_due.size() == 0) begin
         $display("keyed_counter_table_tb: clean");
      end else begin
         $display("keyed_counter_table_tb: errors");
      end
      $finish;
   end

endmodule
